// ===== rtl/i2a_pkg.sv =====
`default_nettype none
package i2a_pkg;

   // width of the value field on the request channel
   localparam int VALUE_W = 64;

   // ascii codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_LOW_A = 7'h61;
   localparam logic [6:0] CHAR_UP_A  = 7'h41;

   typedef enum logic [2:0] {
      CMD_UDEC = 3'd0,
      CMD_SDEC = 3'd1,
      CMD_HEXL = 3'd2,
      CMD_HEXU = 3'd3,
      CMD_NEGZ = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_SIGN_PRE,
      ST_PAD,
      ST_SIGN_POST,
      ST_DIGITS
   } state_type;

   // control shared by every cell of the digit row
   typedef struct packed {
      logic clear;
      logic shift_bit;
      logic shift_digit;
      logic dec_mode;
   } chain_ctrl_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d,
                                             input logic       hex,
                                             input logic       upper);
      logic [6:0] c;
      if (!hex || d < 4'd10) begin
         c = CHAR_ZERO + {3'b000, d};
      end else if (upper) begin
         c = CHAR_UP_A + {3'b000, d} - 7'd10;
      end else begin
         c = CHAR_LOW_A + {3'b000, d} - 7'd10;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/i2a_digit_cell.sv =====
`default_nettype none
module i2a_digit_cell (
   input  wire                         clock,
   input  i2a_pkg::chain_ctrl_type     ctrl,
   input  wire                         carry_in,
   input  wire  [3:0]                  digit_below,
   output logic [3:0]                  digit,
   output logic                        carry_out
);
   import i2a_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   // add-3 correction before the doubling step in decimal mode
   always_comb begin
      if (ctrl.dec_mode && digit_ff >= 4'd5) begin
         adj = digit_ff + 4'd3;
      end else begin
         adj = digit_ff;
      end
   end

   assign carry_out = adj[3];

   always_comb begin
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.shift_bit) begin
         digit_in = {adj[2:0], carry_in};
      end else if (ctrl.shift_digit) begin
         digit_in = digit_below;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule
`default_nettype wire

// ===== rtl/i2a_digit_chain.sv =====
`default_nettype none
module i2a_digit_chain #(
   parameter int NDIG = 20
) (
   input  wire                          clock,
   input  i2a_pkg::chain_ctrl_type      ctrl,
   input  wire                          bit_in,
   output logic [$clog2(NDIG)-1:0]      top_idx,
   output logic [3:0]                   top_digit
);
   import i2a_pkg::*;

   localparam int TW = $clog2(NDIG);

   logic [3:0]    digit_w [NDIG];
   logic [NDIG:0] carry_w;
   logic [TW-1:0] top_ff;
   logic [TW-1:0] top_in;

   assign carry_w[0] = bit_in;

   for (genvar i = 0; i < NDIG; i++) begin : g_cell
      logic [3:0] lower_digit;
      if (i == 0) begin : g_first
         assign lower_digit = 4'd0;
      end else begin : g_rest
         assign lower_digit = digit_w[i-1];
      end
      i2a_digit_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .carry_in    (carry_w[i]),
         .digit_below (lower_digit),
         .digit       (digit_w[i]),
         .carry_out   (carry_w[i+1])
      );
   end

   // highest nonzero cell moves up by one when its carry spills; clear zeroes it
   always_comb begin
      top_in = top_ff;
      if (ctrl.clear) begin
         top_in = '0;
      end else if (ctrl.shift_bit && carry_w[top_ff + TW'(1)]
                   && top_ff != TW'(NDIG - 1)) begin
         top_in = top_ff + TW'(1);
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   assign top_idx   = top_ff;
   assign top_digit = digit_w[top_ff];

endmodule
`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
`default_nettype none
// channel   direction  handshake           payload
// req_      in         req_valid/req_stall value, command, min_width, zero_pad
// rsp_      out        rsp_valid/rsp_stall out_char, last
//
// a number is loaded, shifted bit by bit through the digit cell row (shift-add-3
// in decimal), sized, then one character per cycle while unstalled (1 to 63 chars)
// the digit cell row is the pacing unit: one magnitude bit enters per cycle
// req_stall stays high from the load until the last character is registered
// a stalled result holds in the output register; the character feed waits on it
// reset is synchronous, active high, and clears the sequencer and output valid
module integer_to_ascii_formatter #(
   parameter int VALUE_BITS = 64,
   parameter int MAX_WIDTH  = 63
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [i2a_pkg::VALUE_W-1:0] req_value,
   input  wire  [2:0]                  req_command,
   input  wire  [5:0]                  req_min_width,
   input  wire                         req_zero_pad,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [6:0]                  rsp_out_char,
   output logic                        rsp_last
);
   import i2a_pkg::*;

   // decimal digits needed for the full magnitude range (log10(2) scaled)
   localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int TW    = $clog2(NDIG);
   localparam int CNT_W = $clog2(VALUE_BITS);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic                  neg_ff, neg_in;
   logic                  pad0_ff, pad0_in;
   logic                  hex_ff, hex_in;
   logic                  upper_ff, upper_in;
   logic [5:0]            width_ff, width_in;
   logic [5:0]            pad_cnt_ff, pad_cnt_in;
   logic [TW-1:0]         dig_cnt_ff, dig_cnt_in;
   logic                  rsp_valid_ff;
   logic [6:0]            out_char_ff, out_char_in;
   logic                  last_ff, last_in;

   chain_ctrl_type        ctrl;
   logic [TW-1:0]         top_idx;
   logic [3:0]            top_digit;

   logic                  req_xfer;
   logic                  out_free;
   logic                  load;
   logic [VALUE_BITS-1:0] raw;
   logic [5:0]            len;
   logic                  is_signed;

   assign req_xfer = req_valid && !req_stall;
   // output register can take a new character this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign raw = req_value[VALUE_BITS-1:0];
   // characters in sign plus digits
   assign len = 6'(top_idx) + 6'd1 + {5'd0, neg_ff};

   i2a_digit_chain #(
      .NDIG (NDIG)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .bit_in    (mag_ff[VALUE_BITS-1]),
      .top_idx   (top_idx),
      .top_digit (top_digit)
   );

   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      bit_cnt_in  = bit_cnt_ff;
      neg_in      = neg_ff;
      pad0_in     = pad0_ff;
      hex_in      = hex_ff;
      upper_in    = upper_ff;
      width_in    = width_ff;
      pad_cnt_in  = pad_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      out_char_in = out_char_ff;
      last_in     = 1'b0;
      load        = 1'b0;
      is_signed   = 1'b0;
      ctrl.clear       = 1'b0;
      ctrl.shift_bit   = 1'b0;
      ctrl.shift_digit = 1'b0;
      ctrl.dec_mode    = !hex_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               is_signed  = (req_command == CMD_SDEC) && raw[VALUE_BITS-1];
               // two's complement negate; the most negative value maps onto itself
               mag_in     = is_signed ? (~raw + VALUE_BITS'(1)) : raw;
               neg_in     = is_signed || (req_command == CMD_NEGZ);
               hex_in     = req_command inside {CMD_HEXL, CMD_HEXU};
               upper_in   = (req_command == CMD_HEXU);
               pad0_in    = req_zero_pad;
               width_in   = (req_min_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                            : req_min_width;
               bit_cnt_in = CNT_W'(VALUE_BITS - 1);
               ctrl.clear = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // msb of the magnitude walks into the low cell each cycle
            ctrl.shift_bit = 1'b1;
            mag_in         = mag_ff << 1;
            bit_cnt_in     = bit_cnt_ff - CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            pad_cnt_in = (width_ff > len) ? (width_ff - len) : 6'd0;
            dig_cnt_in = top_idx;
            if (neg_ff && pad0_ff) begin
               state_in = ST_SIGN_PRE;
            end else if (pad_cnt_in != 6'd0) begin
               state_in = ST_PAD;
            end else if (neg_ff) begin
               state_in = ST_SIGN_POST;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_SIGN_PRE: begin
            if (out_free) begin
               load        = 1'b1;
               out_char_in = CHAR_MINUS;
               state_in    = (pad_cnt_ff != 6'd0) ? ST_PAD : ST_DIGITS;
            end
         end
         ST_PAD: begin
            if (out_free) begin
               load        = 1'b1;
               out_char_in = pad0_ff ? CHAR_ZERO : CHAR_SPACE;
               pad_cnt_in  = pad_cnt_ff - 6'd1;
               if (pad_cnt_ff == 6'd1) begin
                  state_in = (neg_ff && !pad0_ff) ? ST_SIGN_POST : ST_DIGITS;
               end
            end
         end
         ST_SIGN_POST: begin
            if (out_free) begin
               load        = 1'b1;
               out_char_in = CHAR_MINUS;
               state_in    = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               // top cell holds the next digit; the row moves up one place
               load             = 1'b1;
               out_char_in      = digit_char(top_digit, hex_ff, upper_ff);
               ctrl.shift_digit = 1'b1;
               dig_cnt_in       = dig_cnt_ff - TW'(1);
               if (dig_cnt_ff == '0) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and working registers, no reset needed
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bit_cnt_ff <= bit_cnt_in;
      neg_ff     <= neg_in;
      pad0_ff    <= pad0_in;
      hex_ff     <= hex_in;
      upper_ff   <= upper_in;
      width_ff   <= width_in;
      pad_cnt_ff <= pad_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      if (load) begin
         out_char_ff <= out_char_in;
         last_ff     <= last_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

// ===== verif/integer_to_ascii_formatter_tb.sv =====
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;
   import i2a_pkg::*;

   // command codes the block treats like unsigned decimal
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam logic [63:0] RADIX_DEC    = 64'd10;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SIGN_ONLY    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] LARGEST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [5:0]  WIDEST       = 6'd63;
   localparam int          RANDOM_ITEMS = 150;
   // conversion pass plus load and sizing, with margin
   localparam int          SETTLE_CYCLES = 80;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } ascii_beat_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // every input known from time zero
   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [63:0] req_value     = '0;
   logic [2:0]  req_command   = CMD_UDEC;
   logic [5:0]  req_min_width = '0;
   logic        req_zero_pad  = 1'b0;
   logic        rsp_stall     = 1'b0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [6:0]  rsp_out_char;
   wire         rsp_last;

   // characters still owed by the block, oldest first
   ascii_beat_type expected_chars[$];
   ascii_beat_type oldest_char;

   int             mismatches    = 0;
   int             chars_checked = 0;
   int             numbers_done  = 0;
   int             char_index    = 0;
   int             cycle_count   = 0;
   int             burst_left    = 0;
   int             stall_left    = 0;
   stall_mode_type stall_mode    = STALL_NONE;
   int             command_seen[8];

   integer_to_ascii_formatter #(
      .VALUE_BITS(64),
      .MAX_WIDTH (63)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_command  (req_command),
      .req_min_width(req_min_width),
      .req_zero_pad (req_zero_pad),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // cycle counter doubles as the watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still owed",
                  cycle_count, expected_chars.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // formats one number the way the block should and queues its characters
   function automatic void format_number(input logic [63:0] raw,
                                         input logic [2:0]  cmd,
                                         input logic [5:0]  min_w,
                                         input logic        pad);
      logic [63:0] mag;
      logic [3:0]  d;
      logic        neg;
      logic        hex;
      logic [6:0]  text[$];
      int          fill;
      mag = raw;
      neg = 1'b0;
      hex = (cmd == CMD_HEXL) || (cmd == CMD_HEXU);
      if (cmd == CMD_SDEC && raw[63]) begin
         // two's complement magnitude; the sign bit alone maps onto itself
         mag = -raw;
         neg = 1'b1;
      end else if (cmd == CMD_NEGZ) begin
         neg = 1'b1;
      end
      // digits least significant first; zero still yields one digit
      do begin
         if (hex) begin
            d = mag[3:0];
            mag = mag >> 4;
         end else begin
            d = 4'(mag % RADIX_DEC);
            mag = mag / RADIX_DEC;
         end
         if (d < 4'd10) begin
            text.push_front(CHAR_ZERO + {3'b000, d});
         end else if (cmd == CMD_HEXU) begin
            text.push_front(CHAR_UP_A + {3'b000, d} - 7'd10);
         end else begin
            text.push_front(CHAR_LOW_A + {3'b000, d} - 7'd10);
         end
      end while (mag != 0);
      fill = int'(min_w) - text.size() - (neg ? 1 : 0);
      // space fill goes ahead of the sign, zero fill after it
      if (neg && !pad) begin
         text.push_front(CHAR_MINUS);
      end
      repeat (fill > 0 ? fill : 0) text.push_front(pad ? CHAR_ZERO : CHAR_SPACE);
      if (neg && pad) begin
         text.push_front(CHAR_MINUS);
      end
      foreach (text[i]) begin
         expected_chars.push_back('{text[i], (i == text.size() - 1)});
      end
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endfunction

   // receiver: stall pattern changes every so often, including quiet stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (cycle_count % 3 == 0);
         end
      endcase
   end

   // checks every accepted character against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                    rsp_out_char, rsp_last));
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_out_char !== oldest_char.ch || rsp_last !== oldest_char.last) begin
               note_mismatch($sformatf(
                  "number %0d char %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
                  numbers_done, char_index, oldest_char.ch, oldest_char.last,
                  rsp_out_char, rsp_last));
            end
         end
         if (rsp_last === 1'b1) begin
            numbers_done++;
            char_index = 0;
         end else begin
            char_index++;
         end
      end
   end

   // sender pacing: bursts of back-to-back requests split by gaps
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         case ($urandom_range(0, 2))
            0: gap = 0;
            1: gap = $urandom_range(1, 8);
            default: gap = $urandom_range(1, 150);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // one request transfer; expectations are queued at the accepting edge
   task automatic send_number(input logic [63:0] value,
                              input logic [2:0]  cmd,
                              input logic [5:0]  min_w,
                              input logic        pad);
      pace_sender();
      req_valid     <= 1'b1;
      req_value     <= value;
      req_command   <= cmd;
      req_min_width <= min_w;
      req_zero_pad  <= pad;
      do @(posedge clock); while (req_stall);
      format_number(value, cmd, min_w, pad);
      command_seen[cmd]++;
   endtask

   // hold off until every owed character has come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_extremes();
      send_number('0,       CMD_UDEC, 6'd0,   1'b0);
      send_number(ALL_ONES, CMD_UDEC, 6'd0,   1'b0);
      send_number(ALL_ONES, CMD_HEXL, 6'd0,   1'b1);
      send_number(ALL_ONES, CMD_HEXU, WIDEST, 1'b1);
      send_number('0,       CMD_HEXU, 6'd0,   1'b0);
      send_number(64'h5555_5555_5555_5555, CMD_UDEC, 6'd3, 1'b0);
      send_number(64'hAAAA_AAAA_AAAA_AAAA, CMD_HEXL, 6'd3, 1'b0);
   endtask

   task automatic check_every_command();
      send_number(64'h0123_4567_89AB_CDEF, CMD_HEXL, 6'd0, 1'b0);
      send_number(64'h0123_4567_89AB_CDEF, CMD_HEXU, 6'd0, 1'b0);
      send_number(ALL_ONES,    CMD_SDEC, 6'd0, 1'b0);
      send_number(LARGEST_POS, CMD_SDEC, 6'd0, 1'b0);
      // most negative signed value prints its full magnitude
      send_number(SIGN_ONLY,   CMD_SDEC, 6'd0, 1'b0);
      // forced negative: zero gives a minus and a zero
      send_number('0,          CMD_NEGZ, 6'd0, 1'b0);
      send_number(64'd12345,   CMD_NEGZ, 6'd8, 1'b1);
      // spare codes fall back to unsigned decimal
      send_number(64'd42,      CMD_SPARE_5, 6'd0, 1'b0);
      send_number(SIGN_ONLY,   CMD_SPARE_6, 6'd0, 1'b0);
      send_number(64'd7,       CMD_SPARE_7, 6'd4, 1'b1);
   endtask

   task automatic check_sign_and_fill();
      send_number(-64'd42, CMD_SDEC, 6'd8,   1'b0);
      send_number(-64'd42, CMD_SDEC, 6'd8,   1'b1);
      send_number('0,      CMD_NEGZ, WIDEST, 1'b1);
      send_number('0,      CMD_NEGZ, WIDEST, 1'b0);
      send_number(64'd255, CMD_HEXL, WIDEST, 1'b0);
      // exact fit and narrower than the text: no fill
      send_number(64'd99,  CMD_UDEC, 6'd2,   1'b1);
      send_number(64'd99,  CMD_UDEC, 6'd1,   1'b0);
      send_number(SIGN_ONLY, CMD_SDEC, 6'd21, 1'b1);
   endtask

   // mixed random numbers, with one full drain part way through
   task automatic check_random_numbers();
      logic [63:0] value;
      logic [63:0] pow10;
      logic [2:0]  cmd;
      logic [5:0]  min_w;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            wait_until_drained();
         end
         case ($urandom_range(0, 5))
            0: value = 64'($urandom_range(0, 20));
            1: value = {$urandom(), $urandom()};
            2: begin
               // around a power of ten, where digit counts change
               pow10 = 64'd1;
               repeat ($urandom_range(0, 19)) pow10 = pow10 * RADIX_DEC;
               value = pow10 - 64'd1 + 64'($urandom_range(0, 2));
            end
            3: value = -64'($urandom_range(1, 1000));
            4: value = ALL_ONES >> $urandom_range(0, 63);
            default: value = 64'd1 << $urandom_range(0, 63);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
         end else begin
            cmd = 3'($urandom_range(CMD_UDEC, CMD_NEGZ));
         end
         if ($urandom_range(0, 7) == 0) begin
            min_w = 6'($urandom_range(0, 63));
         end else begin
            min_w = 6'($urandom_range(0, 24));
         end
         send_number(value, cmd, min_w, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      check_extremes();
      check_every_command();
      check_sign_and_fill();
      wait_until_drained();
      check_random_numbers();
      wait_until_drained();
      $display("covered %0d numbers: %0d unsigned, %0d signed, %0d hex, %0d forced negative",
               numbers_done, command_seen[CMD_UDEC], command_seen[CMD_SDEC],
               command_seen[CMD_HEXL] + command_seen[CMD_HEXU], command_seen[CMD_NEGZ]);
      $display("%0d on spare codes, %0d characters checked, %0d mismatches",
               command_seen[CMD_SPARE_5] + command_seen[CMD_SPARE_6]
               + command_seen[CMD_SPARE_7], chars_checked, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/i2a_pkg.sv
rtl/i2a_digit_cell.sv
rtl/i2a_digit_chain.sv
rtl/integer_to_ascii_formatter.sv
verif/integer_to_ascii_formatter_tb.sv
